FILE: src/cpu8ex_pkg.sv
// Shared types and constants for the 8-bit CPU execute unit.
// Used by cpu8ex_alu and cpu8_load_inc_add16_execute; depends on nothing.
package cpu8ex_pkg;

    // access kinds reported with each result
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_RMW   = 2'd3;

    // low-nibble opcode groups inside the 0x00..0x3F row block
    localparam logic [3:0] OPL_LD_RR_IMM = 4'h1;
    localparam logic [3:0] OPL_ST_IND_A  = 4'h2;
    localparam logic [3:0] OPL_INC_RR    = 4'h3;
    localparam logic [3:0] OPL_INC_HI    = 4'h4;
    localparam logic [3:0] OPL_LD_SP     = 4'h8;
    localparam logic [3:0] OPL_ADD_HL    = 4'h9;
    localparam logic [3:0] OPL_LD_A_IND  = 4'hA;
    localparam logic [3:0] OPL_INC_LO    = 4'hC;

    localparam logic [7:0] OP_LD_A16_SP  = 8'h08;
    localparam logic [1:0] OP_ROW_BLOCK  = 2'b00;

    // register pair selects (opcode bits 5:4)
    localparam logic [1:0] SEL_BC = 2'd0;
    localparam logic [1:0] SEL_DE = 2'd1;
    localparam logic [1:0] SEL_HL = 2'd2;
    localparam logic [1:0] SEL_SP = 2'd3;

    localparam logic [4:0] CYC_BAD  = 5'd0;
    localparam logic [4:0] CYC_4    = 5'd4;
    localparam logic [4:0] CYC_8    = 5'd8;
    localparam logic [4:0] CYC_12   = 5'd12;
    localparam logic [4:0] CYC_20   = 5'd20;

    typedef struct packed {
        logic [7:0]  a;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic [15:0] sp;
        logic [3:0]  flags;   // Z N H C
    } cpu_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [4:0]  cycles;
        logic        bad;
        logic        last;
    } result_t;

endpackage

FILE: src/cpu8ex_alu.sv
// Combinational execute logic: decodes one opcode, computes the next register
// state and the result of the current transfer. Depends on cpu8ex_pkg.
module cpu8ex_alu
    import cpu8ex_pkg::*;
(
    input  logic [7:0]  opcode,
    input  logic [15:0] immediate,
    input  logic [7:0]  read_data,
    input  logic        second,
    input  cpu_state_t  cur,
    output cpu_state_t  nxt,
    output result_t     res,
    output logic        two_write
);

    logic [1:0]  sel;
    logic [15:0] pair_val;
    logic [16:0] add_sum;
    logic [12:0] add_low;
    logic [7:0]  inc_in;
    logic [7:0]  inc_out;
    logic [3:0]  inc_flags;
    logic [15:0] ind_addr;

    assign sel = opcode[5:4];

    always_comb
    begin
        unique case (sel)
            SEL_BC: pair_val = cur.bc;
            SEL_DE: pair_val = cur.de;
            SEL_HL: pair_val = cur.hl;
            SEL_SP: pair_val = cur.sp;
        endcase
    end

    assign ind_addr  = (sel == SEL_BC) ? cur.bc : ((sel == SEL_DE) ? cur.de : cur.hl);
    assign add_sum   = {1'b0, cur.hl} + {1'b0, pair_val};
    assign add_low   = {1'b0, cur.hl[11:0]} + {1'b0, pair_val[11:0]};

    // one 8-bit incrementer shared by INC r and INC (HL)
    always_comb
    begin
        if (opcode[3:0] == OPL_INC_LO)
        begin
            inc_in = (sel == SEL_SP) ? cur.a : pair_val[7:0];
        end
        else
        begin
            inc_in = (sel == SEL_SP) ? read_data : pair_val[15:8];
        end
    end

    assign inc_out   = inc_in + 8'd1;
    assign inc_flags = {inc_in == 8'hFF, 1'b0, inc_in[3:0] == 4'hF, cur.flags[0]};

    always_comb
    begin
        nxt       = cur;
        two_write = 1'b0;
        res       = '{kind: KIND_NONE, addr: 16'd0, data: 8'd0, cycles: CYC_BAD,
                      bad: 1'b0, last: 1'b1};
        if (second)
        begin
            // high byte of SP for LD (a16),SP
            two_write  = 1'b1;
            res.kind   = KIND_WRITE;
            res.addr   = immediate + 16'd1;
            res.data   = cur.sp[15:8];
            res.cycles = CYC_20;
        end
        else if (opcode[7:6] == OP_ROW_BLOCK)
        begin
            unique case (opcode[3:0])
                OPL_LD_RR_IMM:
                begin
                    unique case (sel)
                        SEL_BC: nxt.bc = immediate;
                        SEL_DE: nxt.de = immediate;
                        SEL_HL: nxt.hl = immediate;
                        SEL_SP: nxt.sp = immediate;
                    endcase
                    res.cycles = CYC_12;
                end
                OPL_ST_IND_A, OPL_LD_A_IND:
                begin
                    if (sel == SEL_HL)
                    begin
                        nxt.hl = cur.hl + 16'd1;
                    end
                    else if (sel == SEL_SP)
                    begin
                        nxt.hl = cur.hl - 16'd1;
                    end
                    res.addr   = ind_addr;
                    res.cycles = CYC_8;
                    if (opcode[3:0] == OPL_ST_IND_A)
                    begin
                        res.kind = KIND_WRITE;
                        res.data = cur.a;
                    end
                    else
                    begin
                        res.kind = KIND_READ;
                        res.data = read_data;
                        nxt.a    = read_data;
                    end
                end
                OPL_INC_RR:
                begin
                    unique case (sel)
                        SEL_BC: nxt.bc = pair_val + 16'd1;
                        SEL_DE: nxt.de = pair_val + 16'd1;
                        SEL_HL: nxt.hl = pair_val + 16'd1;
                        SEL_SP: nxt.sp = pair_val + 16'd1;
                    endcase
                    res.cycles = CYC_8;
                end
                OPL_ADD_HL:
                begin
                    nxt.hl     = add_sum[15:0];
                    nxt.flags  = {cur.flags[3], 1'b0, add_low[12], add_sum[16]};
                    res.cycles = CYC_8;
                end
                OPL_LD_SP:
                begin
                    if (opcode == OP_LD_A16_SP)
                    begin
                        two_write  = 1'b1;
                        res.kind   = KIND_WRITE;
                        res.addr   = immediate;
                        res.data   = cur.sp[7:0];
                        res.cycles = CYC_20;
                        res.last   = 1'b0;
                    end
                    else
                    begin
                        res.bad = 1'b1;
                    end
                end
                OPL_INC_HI:
                begin
                    nxt.flags  = inc_flags;
                    res.cycles = CYC_4;
                    unique case (sel)
                        SEL_BC: nxt.bc[15:8] = inc_out;
                        SEL_DE: nxt.de[15:8] = inc_out;
                        SEL_HL: nxt.hl[15:8] = inc_out;
                        SEL_SP:
                        begin
                            res.kind   = KIND_RMW;
                            res.addr   = cur.hl;
                            res.data   = inc_out;
                            res.cycles = CYC_12;
                        end
                    endcase
                end
                OPL_INC_LO:
                begin
                    nxt.flags  = inc_flags;
                    res.cycles = CYC_4;
                    unique case (sel)
                        SEL_BC: nxt.bc[7:0] = inc_out;
                        SEL_DE: nxt.de[7:0] = inc_out;
                        SEL_HL: nxt.hl[7:0] = inc_out;
                        SEL_SP: nxt.a       = inc_out;
                    endcase
                end
                default:
                begin
                    res.bad = 1'b1;
                end
            endcase
        end
        else
        begin
            res.bad = 1'b1;
        end
    end

endmodule

FILE: src/cpu8_load_inc_add16_execute.sv
// Top level of the 8-bit CPU execute unit: input register, register file,
// result register and handshake control. Depends on cpu8ex_pkg, cpu8ex_alu.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   in      | input     | in_valid/in_stall  | opcode, immediate, read_data
//   out     | output    | out_valid/out_stall| access_kind .. flags (one per access)
//
// An instruction is latched in the input register, executed combinationally
// and captured in the result register, which drives the outputs.
// One instruction per cycle is sustained while out_stall is low; LD (a16),SP
// holds the input register for a second phase to issue its second write result.
// Reset clears all CPU registers and flags to zero and empties both stages.
// out_stall holds the result register, and through it the input register.
module cpu8_load_inc_add16_execute
    import cpu8ex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  opcode,
    input  logic [15:0] immediate,
    input  logic [7:0]  read_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  access_kind,
    output logic [15:0] mem_addr,
    output logic [7:0]  mem_data,
    output logic [4:0]  cycles,
    output logic        bad_opcode,
    output logic        last,
    output logic [7:0]  reg_a,
    output logic [15:0] reg_bc,
    output logic [15:0] reg_de,
    output logic [15:0] reg_hl,
    output logic [15:0] reg_sp,
    output logic [3:0]  flags
);

    logic        s1_valid_reg;
    logic [7:0]  s1_opcode_reg;
    logic [15:0] s1_imm_reg;
    logic [7:0]  s1_rd_reg;
    logic        phase_reg;
    cpu_state_t  state_reg;
    logic        out_valid_reg;
    result_t     out_res_reg;
    cpu_state_t  out_state_reg;

    cpu_state_t  state_next;
    result_t     res_next;
    logic        two_write;
    logic        out_free;
    logic        exec_fire;
    logic        s1_done;
    logic        in_xfer;

    cpu8ex_alu u_alu (
        .opcode    (s1_opcode_reg),
        .immediate (s1_imm_reg),
        .read_data (s1_rd_reg),
        .second    (phase_reg),
        .cur       (state_reg),
        .nxt       (state_next),
        .res       (res_next),
        .two_write (two_write)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign exec_fire = s1_valid_reg && out_free;
    assign s1_done   = exec_fire && (!two_write || phase_reg);
    assign in_stall  = s1_valid_reg && !s1_done;
    assign in_xfer   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_done)
            begin
                phase_reg <= 1'b0;
            end
            else if (exec_fire && two_write)
            begin
                phase_reg <= 1'b1;
            end
            out_valid_reg <= exec_fire || (out_valid_reg && out_stall);
            // commit the register file once per instruction
            if (exec_fire && !phase_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_opcode_reg <= opcode;
            s1_imm_reg    <= immediate;
            s1_rd_reg     <= read_data;
        end
        if (exec_fire)
        begin
            out_res_reg   <= res_next;
            out_state_reg <= state_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign access_kind = out_res_reg.kind;
    assign mem_addr    = out_res_reg.addr;
    assign mem_data    = out_res_reg.data;
    assign cycles      = out_res_reg.cycles;
    assign bad_opcode  = out_res_reg.bad;
    assign last        = out_res_reg.last;
    assign reg_a       = out_state_reg.a;
    assign reg_bc      = out_state_reg.bc;
    assign reg_de      = out_state_reg.de;
    assign reg_hl      = out_state_reg.hl;
    assign reg_sp      = out_state_reg.sp;
    assign flags       = out_state_reg.flags;

`ifndef ASSERT_OFF
    a_phase_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> s1_valid_reg)
        else $error("second-write phase without a held instruction");

    a_phase_only_sp_store: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (s1_opcode_reg == OP_LD_A16_SP))
        else $error("second-write phase for an opcode other than LD (a16),SP");

    a_first_write_enters_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && !phase_reg && two_write) |=> phase_reg)
        else $error("first write of LD (a16),SP not followed by second phase");

    a_not_last_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_res_reg.last) |-> (s1_valid_reg && phase_reg))
        else $error("non-final result shown without its second write pending");
`endif

endmodule

FILE: test/cpu8_load_inc_add16_execute_test.sv
// Testbench for cpu8_load_inc_add16_execute: directed table, then random opcode streams
// checked against an in-bench register model. Depends on cpu8ex_pkg and the execute unit.
module cpu8_load_inc_add16_execute_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cpu8ex_pkg::*;

    localparam int unsigned LONG_HOLD_CYCLES = 80;

    typedef struct packed {
        result_t    access;
        cpu_state_t regs;
    } exec_record_t;

    typedef struct packed {
        logic [7:0]   op;
        logic [15:0]  imm;
        logic [7:0]   rd;
        logic         typed;
        exec_record_t want;
    } stim_row_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [7:0]  opcode     = 8'h00;
    logic [15:0] immediate  = 16'h0000;
    logic [7:0]  read_data  = 8'h00;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [1:0]  access_kind;
    logic [15:0] mem_addr;
    logic [7:0]  mem_data;
    logic [4:0]  cycles;
    logic        bad_opcode;
    logic        last;
    logic [7:0]  reg_a;
    logic [15:0] reg_bc;
    logic [15:0] reg_de;
    logic [15:0] reg_hl;
    logic [15:0] reg_sp;
    logic [3:0]  flags;

    cpu_state_t   model_regs = '0;
    exec_record_t outcomes_due[$];
    stim_row_t    directed_rows [25];

    int unsigned mismatch_count    = 0;
    int unsigned results_seen      = 0;
    int unsigned sink_hold_left    = 0;
    bit          src_gaps_on       = 1'b1;
    bit          sink_gaps_on      = 1'b1;
    bit          long_hold_pending = 1'b0;

    cpu8_load_inc_add16_execute dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .immediate   (immediate),
        .read_data   (read_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .access_kind (access_kind),
        .mem_addr    (mem_addr),
        .mem_data    (mem_data),
        .cycles      (cycles),
        .bad_opcode  (bad_opcode),
        .last        (last),
        .reg_a       (reg_a),
        .reg_bc      (reg_bc),
        .reg_de      (reg_de),
        .reg_hl      (reg_hl),
        .reg_sp      (reg_sp),
        .flags       (flags)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want, input int unsigned seq);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %h, want %h", seq, name, got, want));
    endtask

    // ---------------------------------------------------------------- register model

    function automatic void queue_outcome(input logic [1:0] kind, input logic [15:0] addr,
                                          input logic [7:0] data, input logic [4:0] cyc,
                                          input logic bad, input logic fin);
        exec_record_t r;
        r.access.kind   = kind;
        r.access.addr   = addr;
        r.access.data   = data;
        r.access.cycles = cyc;
        r.access.bad    = bad;
        r.access.last   = fin;
        r.regs          = model_regs;
        outcomes_due.push_back(r);
    endfunction

    // 8-bit increment: Z from the result, H when the low nibble was F, C kept
    function automatic logic [7:0] bump_byte(input logic [7:0] v);
        logic [7:0] r;
        r = v + 8'd1;
        model_regs.flags = {r == 8'h00, 1'b0, v[3:0] == 4'hF, model_regs.flags[0]};
        return r;
    endfunction

    function automatic logic [15:0] pair_value(input logic [1:0] sel);
        case (sel)
            SEL_BC:  return model_regs.bc;
            SEL_DE:  return model_regs.de;
            SEL_HL:  return model_regs.hl;
            default: return model_regs.sp;
        endcase
    endfunction

    function automatic void load_pair(input logic [1:0] sel, input logic [15:0] v);
        case (sel)
            SEL_BC:  model_regs.bc = v;
            SEL_DE:  model_regs.de = v;
            SEL_HL:  model_regs.hl = v;
            default: model_regs.sp = v;
        endcase
    endfunction

    task automatic run_instruction(input logic [7:0] op, input logic [15:0] imm,
                                   input logic [7:0] rd);
        logic [1:0]  sel;
        logic [3:0]  grp;
        logic [15:0] addr;
        logic [15:0] operand;
        logic [16:0] sum;
        logic [12:0] low_sum;
        logic [7:0]  new_byte;
        logic        handled;
        sel     = op[5:4];
        grp     = op[3:0];
        handled = 1'b1;
        if (op[7:6] != OP_ROW_BLOCK)
        begin
            handled = 1'b0;
        end
        else
        begin
            case (grp)
                OPL_LD_RR_IMM:
                begin
                    load_pair(sel, imm);
                    queue_outcome(KIND_NONE, 16'h0000, 8'h00, CYC_12, 1'b0, 1'b1);
                end
                OPL_ST_IND_A, OPL_LD_A_IND:
                begin
                    case (sel)
                        SEL_BC:  addr = model_regs.bc;
                        SEL_DE:  addr = model_regs.de;
                        default: addr = model_regs.hl;
                    endcase
                    // HL+ and HL- use the old HL for the access
                    if (sel == SEL_HL)
                        model_regs.hl = model_regs.hl + 16'd1;
                    else if (sel == SEL_SP)
                        model_regs.hl = model_regs.hl - 16'd1;
                    if (grp == OPL_ST_IND_A)
                    begin
                        queue_outcome(KIND_WRITE, addr, model_regs.a, CYC_8, 1'b0, 1'b1);
                    end
                    else
                    begin
                        model_regs.a = rd;
                        queue_outcome(KIND_READ, addr, rd, CYC_8, 1'b0, 1'b1);
                    end
                end
                OPL_INC_RR:
                begin
                    load_pair(sel, pair_value(sel) + 16'd1);
                    queue_outcome(KIND_NONE, 16'h0000, 8'h00, CYC_8, 1'b0, 1'b1);
                end
                OPL_ADD_HL:
                begin
                    operand = pair_value(sel);
                    sum     = {1'b0, model_regs.hl} + {1'b0, operand};
                    low_sum = {1'b0, model_regs.hl[11:0]} + {1'b0, operand[11:0]};
                    model_regs.flags = {model_regs.flags[3], 1'b0, low_sum[12], sum[16]};
                    model_regs.hl    = sum[15:0];
                    queue_outcome(KIND_NONE, 16'h0000, 8'h00, CYC_8, 1'b0, 1'b1);
                end
                OPL_LD_SP:
                begin
                    if (op == OP_LD_A16_SP)
                    begin
                        queue_outcome(KIND_WRITE, imm, model_regs.sp[7:0], CYC_20, 1'b0, 1'b0);
                        queue_outcome(KIND_WRITE, imm + 16'd1, model_regs.sp[15:8], CYC_20,
                                      1'b0, 1'b1);
                    end
                    else
                    begin
                        handled = 1'b0;
                    end
                end
                OPL_INC_HI:
                begin
                    case (sel)
                        SEL_BC:  model_regs.bc[15:8] = bump_byte(model_regs.bc[15:8]);
                        SEL_DE:  model_regs.de[15:8] = bump_byte(model_regs.de[15:8]);
                        SEL_HL:  model_regs.hl[15:8] = bump_byte(model_regs.hl[15:8]);
                        default: ;
                    endcase
                    if (sel == SEL_SP)
                    begin
                        new_byte = bump_byte(rd);
                        queue_outcome(KIND_RMW, model_regs.hl, new_byte, CYC_12, 1'b0, 1'b1);
                    end
                    else
                    begin
                        queue_outcome(KIND_NONE, 16'h0000, 8'h00, CYC_4, 1'b0, 1'b1);
                    end
                end
                OPL_INC_LO:
                begin
                    case (sel)
                        SEL_BC:  model_regs.bc[7:0] = bump_byte(model_regs.bc[7:0]);
                        SEL_DE:  model_regs.de[7:0] = bump_byte(model_regs.de[7:0]);
                        SEL_HL:  model_regs.hl[7:0] = bump_byte(model_regs.hl[7:0]);
                        default: model_regs.a       = bump_byte(model_regs.a);
                    endcase
                    queue_outcome(KIND_NONE, 16'h0000, 8'h00, CYC_4, 1'b0, 1'b1);
                end
                default: handled = 1'b0;
            endcase
        end
        if (!handled)
            queue_outcome(KIND_NONE, 16'h0000, 8'h00, CYC_BAD, 1'b1, 1'b1);
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic stim_row_t plain_row(input logic [7:0] op, input logic [15:0] imm,
                                            input logic [7:0] rd);
        stim_row_t r;
        r       = '0;
        r.op    = op;
        r.imm   = imm;
        r.rd    = rd;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [7:0] op, input logic [15:0] imm,
                                            input logic [7:0] rd, input logic [1:0] kind,
                                            input logic [4:0] cyc, input logic bad,
                                            input logic [7:0] a, input logic [15:0] bc,
                                            input logic [15:0] de, input logic [15:0] hl,
                                            input logic [15:0] sp, input logic [3:0] flg);
        stim_row_t r;
        r                    = plain_row(op, imm, rd);
        r.typed              = 1'b1;
        r.want.access.kind   = kind;
        r.want.access.addr   = 16'h0000;
        r.want.access.data   = 8'h00;
        r.want.access.cycles = cyc;
        r.want.access.bad    = bad;
        r.want.access.last   = 1'b1;
        r.want.regs          = '{a: a, bc: bc, de: de, hl: hl, sp: sp, flags: flg};
        return r;
    endfunction

    function automatic logic [7:0] pick_opcode();
        logic [1:0] sel;
        logic [3:0] grp;
        // some noise over the whole opcode space
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom);
        sel = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 7))
            0:       grp = OPL_LD_RR_IMM;
            1:       grp = OPL_ST_IND_A;
            2:       grp = OPL_INC_RR;
            3:       grp = OPL_INC_HI;
            4:       grp = OPL_ADD_HL;
            5:       grp = OPL_LD_A_IND;
            6:       grp = OPL_INC_LO;
            default: return OP_LD_A16_SP;
        endcase
        return {OP_ROW_BLOCK, sel, grp};
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0FFF;
            3:       return 16'h00FF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h0F;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one instruction and hold it until the transfer; starts and ends at a rising edge.
    task automatic send_instr(input logic [7:0] op, input logic [15:0] imm,
                              input logic [7:0] rd);
        int unsigned gap;
        bit          taken;
        if (src_gaps_on && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        immediate <= imm;
        read_data <= rd;
        do
        begin
            @(negedge clk);
            taken = (in_stall === 1'b0);
            @(posedge clk);
        end while (!taken);
        run_instruction(op, imm, rd);
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) send_instr(pick_opcode(), pick_word(), pick_byte());
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (outcomes_due.size() != 0);
    endtask

    // ---------------------------------------------------------------- result side

    always @(posedge clk)
    begin
        if (sink_hold_left != 0)
        begin
            sink_hold_left--;
            if (sink_hold_left == 0)
                out_stall <= 1'b0;
        end
        else if (long_hold_pending)
        begin
            long_hold_pending = 1'b0;
            sink_hold_left    = LONG_HOLD_CYCLES;
            out_stall        <= 1'b1;
        end
        else if (sink_gaps_on && $urandom_range(0, 7) == 0)
        begin
            sink_hold_left = $urandom_range(1, 19);
            out_stall     <= 1'b1;
        end
    end

    // Sample mid-cycle: what is seen here is what the next rising edge transfers.
    always @(negedge clk)
    begin
        exec_record_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            results_seen++;
            if (outcomes_due.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          results_seen));
            end
            else
            begin
                want = outcomes_due.pop_front();
                check_field("access_kind", 16'(access_kind), 16'(want.access.kind),
                            results_seen);
                check_field("mem_addr", mem_addr, want.access.addr, results_seen);
                check_field("mem_data", 16'(mem_data), 16'(want.access.data), results_seen);
                check_field("cycles", 16'(cycles), 16'(want.access.cycles), results_seen);
                check_field("bad_opcode", 16'(bad_opcode), 16'(want.access.bad),
                            results_seen);
                check_field("last", 16'(last), 16'(want.access.last), results_seen);
                check_field("reg_a", 16'(reg_a), 16'(want.regs.a), results_seen);
                check_field("reg_bc", reg_bc, want.regs.bc, results_seen);
                check_field("reg_de", reg_de, want.regs.de, results_seen);
                check_field("reg_hl", reg_hl, want.regs.hl, results_seen);
                check_field("reg_sp", reg_sp, want.regs.sp, results_seen);
                check_field("flags", 16'(flags), 16'(want.regs.flags), results_seen);
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        int unsigned drain_wait;
        directed_rows = '{
            // bad opcode straight after reset: nothing moves
            typed_row(8'h00, 16'h1234, 8'h5A, KIND_NONE, CYC_BAD, 1'b1,
                      8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0),
            typed_row(8'h01, 16'hFFFF, 8'h00, KIND_NONE, CYC_12, 1'b0,
                      8'h00, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 4'h0),
            plain_row(8'h21, 16'h0FFF, 8'h00),
            plain_row(8'h31, 16'hFFFE, 8'h00),
            plain_row(8'h08, 16'hFFFF, 8'h00),   // second write wraps to 0000
            plain_row(8'h09, 16'h0000, 8'h00),   // half carry and carry out
            plain_row(8'h39, 16'h0000, 8'h00),
            plain_row(8'h03, 16'h0000, 8'h00),   // BC wraps to zero
            plain_row(8'h33, 16'h0000, 8'h00),
            plain_row(8'h11, 16'h0000, 8'h00),
            plain_row(8'h02, 16'h0000, 8'h00),
            plain_row(8'h22, 16'h0000, 8'h00),
            plain_row(8'h32, 16'h0000, 8'h00),
            plain_row(8'h1A, 16'h0000, 8'hFF),
            plain_row(8'h2A, 16'h0000, 8'h00),
            plain_row(8'h3A, 16'h0000, 8'h80),
            plain_row(8'h0A, 16'h0000, 8'h7F),
            plain_row(8'h04, 16'h0000, 8'h00),
            plain_row(8'h24, 16'h0000, 8'h00),
            plain_row(8'h34, 16'h0000, 8'hFF),   // memory byte wraps: Z and H
            plain_row(8'h34, 16'h0000, 8'h0F),
            plain_row(8'h3C, 16'h0000, 8'h00),
            plain_row(8'h0C, 16'h0000, 8'h00),
            plain_row(8'hFF, 16'hFFFF, 8'hFF),
            plain_row(8'h18, 16'h0000, 8'h00)    // low nibble 8 but not LD (a16),SP
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_instr(directed_rows[i].op, directed_rows[i].imm, directed_rows[i].rd);
            if (directed_rows[i].typed)
                outcomes_due[outcomes_due.size() - 1] = directed_rows[i].want;
        end

        send_random(500);

        // back up the pipe: long receiver hold while the source keeps offering
        src_gaps_on       = 1'b0;
        long_hold_pending = 1'b1;
        send_random(60);
        src_gaps_on       = 1'b1;

        wait_until_drained();
        send_random(600);

        // final stretch at full rate on both sides
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        send_random(215);

        in_valid  <= 1'b0;
        drain_wait = 0;
        do
        begin
            @(posedge clk);
            drain_wait++;
        end while (outcomes_due.size() != 0 && drain_wait < 2000);
        repeat (8) @(posedge clk);

        if (outcomes_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", outcomes_due.size()));

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
